[src/dueling_ship_rrip_replacement_unit_macros.svh]
// assertion macros for the replacement unit checker
// no dependencies
`ifndef DUELING_SHIP_RRIP_REPLACEMENT_UNIT_MACROS_SVH
`define DUELING_SHIP_RRIP_REPLACEMENT_UNIT_MACROS_SVH
// assert a property under the active-low reset
`define DSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// assert that a signal carries no unknown bits
`define DSR_ASSERT_KNOWN(label, sig, msg) \
  `DSR_ASSERT(label, !$isunknown(sig), msg)
`endif

[src/dsr_pkg.sv]
// shared constants and types for the replacement unit
// no dependencies
package dsr_pkg;
  localparam int unsigned NumSets = 2048;
  localparam int unsigned NumWays = 16;
  localparam int unsigned SigBits = 15;
  localparam int unsigned DuelPeriod = 64;
  localparam int unsigned SelBits = 10;
  localparam int unsigned RrpvWidth = 2;
  localparam logic [2:0] CtrTop = 3'd7;
  localparam logic [2:0] CtrStart = 3'd3;
  localparam logic [2:0] CtrLimit = 3'd3;
  localparam logic ActVictim = 1'b0;
  localparam logic ActUpdate = 1'b1;
  localparam int unsigned PcBits = 30;
endpackage

[src/dsr_ram.sv]
// generic single-port ram with registered read
// no dependencies
module dsr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

[src/dsr_front.sv]
// front: accepts commands, computes signature and leader class, queues them
// depends on dsr_pkg
module dsr_front #(
  parameter int unsigned NumSets = dsr_pkg::NumSets,
  parameter int unsigned NumWays = dsr_pkg::NumWays,
  parameter int unsigned SigBits = dsr_pkg::SigBits,
  parameter int unsigned DuelPeriod = dsr_pkg::DuelPeriod
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       action_i,
  input  logic [10:0]                set_index_i,
  input  logic [3:0]                 way_i,
  input  logic [dsr_pkg::PcBits-1:0] pc_i,
  input  logic                       hit_i,
  output logic                       full_o,
  output logic                       cmd_valid_o,
  input  logic                       cmd_pop_i,
  output logic                       cmd_act_o,
  output logic [$clog2(NumSets)-1:0] cmd_set_o,
  output logic [$clog2(NumWays)-1:0] cmd_way_o,
  output logic [SigBits-1:0]         cmd_sig_o,
  output logic                       cmd_hit_o,
  output logic                       cmd_lsig_o,
  output logic                       cmd_lstat_o
);
  import dsr_pkg::*;
  localparam int unsigned SetW = $clog2(NumSets);
  localparam int unsigned WayW = $clog2(NumWays);
  localparam int unsigned CmdW = 1 + SetW + WayW + SigBits + 3;
  logic [CmdW-1:0] q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic wp_q, rp_q;
  logic [SetW-1:0] set_w;
  logic [PcBits-1:0] shr;
  logic [SigBits-1:0] sig;
  logic [SetW-1:0] slot;
  logic drop, push;
  assign set_w = SetW'(set_index_i % NumSets);
  assign shr = pc_i >> SigBits;
  assign sig = SigBits'(pc_i ^ shr);
  assign slot = SetW'(set_w % DuelPeriod);
  assign drop = action_i == ActUpdate && 32'(way_i) >= NumWays;
  assign full_o = cnt_q == 2'd2;
  assign push = start_i && !full_o && !drop;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= {action_i, set_w, WayW'(way_i), sig, hit_i,
                            slot == '0, slot == SetW'(1)};
  end
  assign cmd_valid_o = cnt_q != 2'd0;
  assign {cmd_act_o, cmd_set_o, cmd_way_o, cmd_sig_o, cmd_hit_o, cmd_lsig_o,
          cmd_lstat_o} = q_q[rp_q];
endmodule

[src/dsr_back.sv]
// back: read-modify-write of set metadata and counter table, clearing pass
// depends on dsr_pkg and dsr_ram
module dsr_back #(
  parameter int unsigned NumSets = dsr_pkg::NumSets,
  parameter int unsigned NumWays = dsr_pkg::NumWays,
  parameter int unsigned SigBits = dsr_pkg::SigBits,
  parameter int unsigned SelBits = dsr_pkg::SelBits,
  parameter int unsigned RrpvWidth = dsr_pkg::RrpvWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_pop_o,
  output logic                       idle_o,
  input  logic                       cmd_act_i,
  input  logic [$clog2(NumSets)-1:0] cmd_set_i,
  input  logic [$clog2(NumWays)-1:0] cmd_way_i,
  input  logic [SigBits-1:0]         cmd_sig_i,
  input  logic                       cmd_hit_i,
  input  logic                       cmd_lsig_i,
  input  logic                       cmd_lstat_i,
  output logic                       done_o,
  output logic [3:0]                 victim_way_o
);
  import dsr_pkg::*;
  localparam int unsigned SetW = $clog2(NumSets);
  localparam int unsigned WayW = $clog2(NumWays);
  localparam int unsigned SigN = 2 ** SigBits;
  localparam int unsigned ClrN = (NumSets > SigN) ? NumSets : SigN;
  localparam int unsigned ClrW = $clog2(ClrN) + 1;
  localparam int unsigned RowW = NumWays * (RrpvWidth + SigBits + 1);
  localparam logic [RrpvWidth-1:0] RTop = '1;
  localparam logic [SelBits-1:0] SelTop = '1;
  localparam logic [SelBits-1:0] SelMid = SelTop >> 1;

  typedef enum logic [4:0] {
    StClr = 5'b00001, StIdle = 5'b00010, StRead = 5'b00100,
    StCtr = 5'b01000, StWrite = 5'b10000
  } state_e;
  typedef struct packed {
    logic [RrpvWidth-1:0] rr;
    logic [SigBits-1:0]   sig;
    logic                 ru;
  } line_t;

  state_e st_q, st_d;
  logic [ClrW-1:0] clr_q;
  logic [SelBits-1:0] sel_q;
  logic act_q, hit_q, lsig_q, lstat_q;
  logic [SetW-1:0] set_q;
  logic [WayW-1:0] way_q;
  logic [SigBits-1:0] sig_q;
  line_t [NumWays-1:0] row_q;
  logic [2:0] newc_q;

  logic row_we, ctr_we;
  logic [SetW-1:0] row_a;
  logic [SigBits-1:0] ctr_a;
  line_t [NumWays-1:0] row_rd, row_wd, row_clr;
  logic [2:0] ctr_rd, ctr_wd;
  logic [RowW-1:0] row_rd_raw;

  dsr_ram #(.Width(RowW), .Depth(NumSets)) u_row (
    .clk_i, .we_i(row_we), .addr_i(row_a), .wdata_i(RowW'(row_wd)),
    .rdata_o(row_rd_raw));
  assign row_rd = row_rd_raw;
  dsr_ram #(.Width(3), .Depth(SigN)) u_ctr (
    .clk_i, .we_i(ctr_we), .addr_i(ctr_a), .wdata_i(ctr_wd), .rdata_o(ctr_rd));

  logic [RrpvWidth-1:0] top, add;
  logic [WayW-1:0] vic;
  line_t [NumWays-1:0] aged;
  line_t old;
  logic [SelBits-1:0] sel_n;
  logic use_sig;

  always_comb begin
    top = '0;
    for (int i = 0; i < NumWays; i++) if (row_q[i].rr > top) top = row_q[i].rr;
    add = RTop - top;
    vic = '0;
    for (int i = NumWays - 1; i >= 0; i--) begin
      aged[i] = row_q[i];
      aged[i].rr = row_q[i].rr + add;
      if (aged[i].rr == RTop) vic = WayW'(i);
    end
    for (int i = 0; i < NumWays; i++) begin
      row_clr[i].rr = RTop;
      row_clr[i].sig = '0;
      row_clr[i].ru = 1'b0;
    end
  end
  assign old = row_q[way_q];
  always_comb begin
    sel_n = sel_q;
    if (lsig_q && sel_q != '0) sel_n = sel_q - 1'b1;
    else if (lstat_q && sel_q != SelTop) sel_n = sel_q + 1'b1;
    use_sig = lsig_q ? 1'b1 : (lstat_q ? 1'b0 : (sel_n > SelMid));
  end

  always_comb begin
    st_d = st_q;
    row_we = 1'b0;
    ctr_we = 1'b0;
    row_a = cmd_set_i;
    ctr_a = cmd_sig_i;
    row_wd = row_q;
    ctr_wd = ctr_rd;
    cmd_pop_o = 1'b0;
    unique case (st_q)
      StClr: begin
        row_we = clr_q < ClrW'(NumSets);
        ctr_we = clr_q < ClrW'(SigN);
        row_a = SetW'(clr_q);
        ctr_a = SigBits'(clr_q);
        row_wd = row_clr;
        ctr_wd = CtrStart;
        if (clr_q == ClrW'(ClrN - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          st_d = StRead;
        end
      end
      StRead: begin
        row_a = set_q;
        ctr_a = row_rd[way_q].sig;
        st_d = (act_q == ActUpdate && !hit_q) ? StCtr : StWrite;
      end
      StCtr: begin
        ctr_a = old.sig;
        ctr_we = !old.ru && ctr_rd != '0;
        ctr_wd = ctr_rd - 3'd1;
        st_d = StWrite;
      end
      StWrite: begin
        row_a = set_q;
        row_we = 1'b1;
        ctr_a = sig_q;
        st_d = StIdle;
        if (act_q == ActVictim) begin
          row_wd = aged;
        end else if (hit_q) begin
          row_wd[way_q].rr = '0;
          row_wd[way_q].ru = 1'b1;
          ctr_we = newc_q != CtrTop;
          ctr_wd = newc_q + 3'd1;
        end else begin
          row_wd[way_q].sig = sig_q;
          row_wd[way_q].ru = 1'b0;
          row_wd[way_q].rr = (use_sig && newc_q <= CtrLimit) ? RTop : RTop - 1'b1;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr;
      clr_q <= '0;
      sel_q <= SelMid;
      done_o <= 1'b0;
    end else begin
      st_q <= st_d;
      done_o <= st_q == StWrite && act_q == ActVictim;
      if (st_q == StClr) clr_q <= clr_q + 1'b1;
      if (st_q == StWrite && act_q == ActUpdate && !hit_q) sel_q <= sel_n;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      act_q <= cmd_act_i;
      set_q <= cmd_set_i;
      way_q <= cmd_way_i;
      sig_q <= cmd_sig_i;
      hit_q <= cmd_hit_i;
      lsig_q <= cmd_lsig_i;
      lstat_q <= cmd_lstat_i;
    end
    if (st_q == StRead) begin
      row_q <= row_rd;
      newc_q <= ctr_rd;
    end
    if (st_q == StCtr && old.sig == sig_q && ctr_we) newc_q <= ctr_wd;
    if (st_q == StWrite) victim_way_o <= 4'(vic);
  end
  assign idle_o = st_q == StIdle;
endmodule

[src/dueling_ship_rrip_replacement_unit.sv]
// top level of the ship/srrip set-dueling replacement unit
// depends on dsr_pkg, dsr_front, dsr_back
// usage:
//   a command is taken at a clock edge with start high and busy low.
//   action_i 0 asks for a victim way in set_index_i; action_i 1 updates the
//   line (set_index_i, way_i) after an access with pc_i and hit_i.
//   a victim query gives one result: victim_way_o with done_o high for one
//   cycle. an update gives no result; an update to a way beyond the ways
//   present is dropped.
//   the front holds a two-entry command queue; busy is high while it is
//   full or while the clearing pass runs.
//   the back does a read-modify-write of the set row: states idle (pop),
//   read and write for a query or a hit, plus a counter state for a miss
//   (extra counter table read-modify-write for the evicted signature). a
//   query result is registered at the end of the write state; the back
//   takes a new command only after it has finished the last one.
//   after reset a clearing pass writes every set row and counter entry;
//   busy stays high until the pass ends.
//   the receiver cannot stall; results are taken when shown.
module dueling_ship_rrip_replacement_unit #(
  parameter int unsigned NumSets = dsr_pkg::NumSets,
  parameter int unsigned NumWays = dsr_pkg::NumWays,
  parameter int unsigned SigBits = dsr_pkg::SigBits,
  parameter int unsigned DuelPeriod = dsr_pkg::DuelPeriod,
  parameter int unsigned SelBits = dsr_pkg::SelBits,
  parameter int unsigned RrpvWidth = dsr_pkg::RrpvWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action_i,
  input  logic [10:0]                set_index_i,
  input  logic [3:0]                 way_i,
  input  logic [dsr_pkg::PcBits-1:0] pc_i,
  input  logic                       hit_i,
  output logic                       done_o,
  output logic [3:0]                 victim_way_o
);
  import dsr_pkg::*;
  localparam int unsigned SetW = $clog2(NumSets);
  localparam int unsigned WayW = $clog2(NumWays);
  logic full, valid, pop, idle, act, hit, lsig, lstat, clearing_q;
  logic [SetW-1:0] set;
  logic [WayW-1:0] way;
  logic [SigBits-1:0] sig;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clearing_q <= 1'b1;
    else if (idle) clearing_q <= 1'b0;
  end
  assign busy = full || clearing_q;

  dsr_front #(.NumSets(NumSets), .NumWays(NumWays), .SigBits(SigBits),
              .DuelPeriod(DuelPeriod)) u_front (
    .clk_i, .rst_ni, .start_i(start && !clearing_q), .action_i, .set_index_i,
    .way_i, .pc_i, .hit_i, .full_o(full), .cmd_valid_o(valid), .cmd_pop_i(pop),
    .cmd_act_o(act), .cmd_set_o(set), .cmd_way_o(way), .cmd_sig_o(sig),
    .cmd_hit_o(hit), .cmd_lsig_o(lsig), .cmd_lstat_o(lstat));

  dsr_back #(.NumSets(NumSets), .NumWays(NumWays), .SigBits(SigBits),
             .SelBits(SelBits), .RrpvWidth(RrpvWidth)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(valid), .cmd_pop_o(pop), .idle_o(idle),
    .cmd_act_i(act), .cmd_set_i(set), .cmd_way_i(way), .cmd_sig_i(sig),
    .cmd_hit_i(hit), .cmd_lsig_i(lsig), .cmd_lstat_i(lstat), .done_o,
    .victim_way_o);
endmodule

[src/dsr_checker.sv]
// port-level checker for the replacement unit, bound to the top level
// depends on the macros header
`include "dueling_ship_rrip_replacement_unit_macros.svh"
module dsr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       busy,
  input logic       done_o,
  input logic [3:0] victim_way_o
);
  `DSR_ASSERT(a_busy_after_rst, $rose(rst_ni) |-> busy, "busy low after reset")
  `DSR_ASSERT(a_done_single, done_o |=> !done_o, "result longer than a cycle")
  `DSR_ASSERT_KNOWN(a_busy_known, busy, "busy unknown")
  `DSR_ASSERT(a_victim_known, done_o |-> !$isunknown(victim_way_o), "victim way unknown")
endmodule

bind dueling_ship_rrip_replacement_unit dsr_checker u_dsr_checker (
  .clk_i, .rst_ni, .busy, .done_o, .victim_way_o);

[tb/dueling_ship_rrip_replacement_unit_tb.sv]
// self-checking testbench for the ship/srrip set-dueling replacement unit
// depends on dsr_pkg and dueling_ship_rrip_replacement_unit; predicts victim ways from
// its own copy of the replacement state and checks every done_o transaction
module dueling_ship_rrip_replacement_unit_tb;
  import dsr_pkg::*;

  typedef struct packed {
    logic        action;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [29:0] pc;
    logic        hit;
  } cmd_t;

  localparam int unsigned NumRandom = 424;
  localparam int unsigned WatchdogLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic done_o;
  logic [3:0] victim_way_o;
  cmd_t cur_cmd = '0;

  cmd_t cmd_q[$];
  logic [3:0] victim_q[$];
  int unsigned total_cmds;
  int unsigned sent_cnt;
  int unsigned idle_cycles;
  bit failed;

  logic [1:0] rrpv_mem[NumSets][NumWays];
  logic [SigBits-1:0] line_sig_mem[NumSets][NumWays];
  logic line_reused_mem[NumSets][NumWays];
  logic [2:0] sig_ctr_mem[1 << SigBits];
  logic [SelBits-1:0] duel_sel;

  dueling_ship_rrip_replacement_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (cur_cmd.action),
    .set_index_i  (cur_cmd.set_index),
    .way_i        (cur_cmd.way),
    .pc_i         (cur_cmd.pc),
    .hit_i        (cur_cmd.hit),
    .done_o       (done_o),
    .victim_way_o (victim_way_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [SigBits-1:0] pc_signature(logic [29:0] pc);
    logic [29:0] mixed;
    mixed = pc ^ (pc >> SigBits);
    return mixed[SigBits-1:0];
  endfunction

  // advances the replacement state by one accepted transaction
  task automatic replay_access(cmd_t c);
    logic [1:0] top;
    logic [1:0] rr_top;
    logic [3:0] vic;
    logic [SigBits-1:0] sig;
    logic [SigBits-1:0] old_sig;
    logic [5:0] slot;
    bit use_sig;
    int s;
    int w;
    s = c.set_index;
    w = c.way;
    rr_top = '1;
    sig = pc_signature(c.pc);
    slot = c.set_index[5:0];
    if (c.action == ActVictim) begin
      top = '0;
      for (int i = 0; i < NumWays; i++) if (rrpv_mem[s][i] > top) top = rrpv_mem[s][i];
      if (top < rr_top)
        for (int i = 0; i < NumWays; i++) rrpv_mem[s][i] += rr_top - top;
      vic = '0;
      for (int i = NumWays - 1; i >= 0; i--)
        if (rrpv_mem[s][i] == rr_top) vic = 4'(i);
      victim_q.push_back(vic);
    end else if (c.hit) begin
      rrpv_mem[s][w] = '0;
      if (sig_ctr_mem[sig] < CtrTop) sig_ctr_mem[sig]++;
      line_reused_mem[s][w] = 1'b1;
    end else begin
      if (slot == 0 && duel_sel > 0) duel_sel--;
      if (slot == 1 && duel_sel < '1) duel_sel++;
      old_sig = line_sig_mem[s][w];
      if (!line_reused_mem[s][w] && sig_ctr_mem[old_sig] > 0) sig_ctr_mem[old_sig]--;
      line_sig_mem[s][w] = sig;
      line_reused_mem[s][w] = 1'b0;
      if (slot == 0) use_sig = 1;
      else if (slot == 1) use_sig = 0;
      else use_sig = duel_sel > ({SelBits{1'b1}} >> 1);
      rrpv_mem[s][w] = (use_sig && sig_ctr_mem[sig] <= CtrLimit) ? rr_top : rr_top - 2'd1;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin : drv_blk
      int unsigned idle_pct;
      bit taken;
      taken = start && !busy;
      if (taken) replay_access(cur_cmd);
      case (sent_cnt * 4 / (total_cmds + 1))
        1: idle_pct = 88;
        2: idle_pct = 19;
        default: idle_pct = 0;
      endcase
      if (taken || !start) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_cmd <= cmd_q.pop_front();
          sent_cnt++;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (victim_q.size() == 0) begin
        $error("unexpected transaction: victim_way actual %0d", victim_way_o);
        failed = 1;
      end else begin : mon_blk
        logic [3:0] want;
        want = victim_q.pop_front();
        if (victim_way_o !== want) begin
          $error("victim_way mismatch: expected %0d actual %0d", want, victim_way_o);
          failed = 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic cmd_t mk_cmd(logic act, logic [10:0] s, logic [3:0] w, logic [29:0] pc,
                                  logic h);
    cmd_t c;
    c.action = act;
    c.set_index = s;
    c.way = w;
    c.pc = pc;
    c.hit = h;
    return c;
  endfunction

  initial begin : stim_blk
    logic [10:0] set_pool[8];
    logic [29:0] pc_pool[6];
    cmd_t c;
    set_pool = '{11'd0, 11'd1, 11'd64, 11'd65, 11'd2047, 11'd5, 11'd130, 11'd1000};
    foreach (pc_pool[i]) pc_pool[i] = 30'($urandom_range(30'h3fffffff));
    for (int s = 0; s < NumSets; s++)
      for (int w = 0; w < NumWays; w++) begin
        rrpv_mem[s][w] = '1;
        line_sig_mem[s][w] = '0;
        line_reused_mem[s][w] = 1'b0;
      end
    foreach (sig_ctr_mem[i]) sig_ctr_mem[i] = CtrStart;
    duel_sel = {SelBits{1'b1}} >> 1;

    // directed: fresh set, hits, misses on both leader groups, aging, pc extremes
    cmd_q.push_back(mk_cmd(ActVictim, 11'd0, 4'd0, 30'd0, 1'b0));
    cmd_q.push_back(mk_cmd(ActUpdate, 11'd0, 4'd0, 30'd0, 1'b0));
    cmd_q.push_back(mk_cmd(ActUpdate, 11'd0, 4'd0, 30'd0, 1'b1));
    cmd_q.push_back(mk_cmd(ActVictim, 11'd0, 4'd0, 30'd0, 1'b0));
    cmd_q.push_back(mk_cmd(ActUpdate, 11'd1, 4'd15, 30'h3fffffff, 1'b0));
    cmd_q.push_back(mk_cmd(ActUpdate, 11'd1, 4'd15, 30'h3fffffff, 1'b1));
    cmd_q.push_back(mk_cmd(ActVictim, 11'd1, 4'd0, 30'd0, 1'b0));
    cmd_q.push_back(mk_cmd(ActUpdate, 11'd2047, 4'd7, 30'h3fffffff, 1'b0));
    cmd_q.push_back(mk_cmd(ActUpdate, 11'd65, 4'd3, 30'h12345678, 1'b0));
    for (int w = 0; w < NumWays; w++)
      cmd_q.push_back(mk_cmd(ActUpdate, 11'd2047, 4'(w), 30'h2aaaaaaa, 1'b1));
    cmd_q.push_back(mk_cmd(ActVictim, 11'd2047, 4'd0, 30'd0, 1'b0));

    // random: mostly a small pool of sets and pcs so counters and the selector move
    for (int n = 0; n < NumRandom; n++) begin
      if ($urandom_range(99) < 75) begin
        c = mk_cmd($urandom_range(99) < 60, set_pool[$urandom_range(7)],
                   4'($urandom_range(15)), pc_pool[$urandom_range(5)], 1'($urandom));
      end else begin
        c = mk_cmd(1'($urandom), 11'($urandom), 4'($urandom), 30'($urandom), 1'($urandom));
      end
      cmd_q.push_back(c);
    end
    total_cmds = cmd_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (cmd_q.size() == 0);
    @(posedge clk_i);
    while (start || victim_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
